FILE: rtl/htfc_pkg.sv
// Package for the humidity/temperature frame checker.
// Holds the CRC-8 step function, scale constants, status codes and the
// frame-to-converter struct. No dependencies.
package htfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned PosW  = 3;
  localparam int unsigned ValW  = 15;
  localparam int unsigned StatW = 2;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  // byte positions within a reply
  localparam logic [PosW-1:0] POS_T_MSB = 3'd0;
  localparam logic [PosW-1:0] POS_T_LSB = 3'd1;
  localparam logic [PosW-1:0] POS_T_CRC = 3'd2;
  localparam logic [PosW-1:0] POS_H_MSB = 3'd3;
  localparam logic [PosW-1:0] POS_H_LSB = 3'd4;

  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_TEMP_BAD = 2'd1;
  localparam logic [StatW-1:0] STAT_HUMI_BAD = 2'd2;

  localparam int unsigned TProdW = 31;
  localparam int unsigned HProdW = 30;
  localparam logic [TProdW-1:0] TempScale  = 31'd17500;
  localparam logic [HProdW-1:0] HumiScale  = 30'd12500;
  localparam logic [ValW:0]     TempOffset = 16'd4500;
  localparam logic [ValW:0]     HumiOffset = 16'd600;
  localparam logic [WordW:0]    WordMax    = 17'd65535;

  typedef struct packed {
    logic             last;
    logic             temp_bad;
    logic             humi_bad;
    logic [WordW-1:0] temp_ticks;
    logic [WordW-1:0] humi_ticks;
  } frame_t;

  function automatic logic [ByteW-1:0] crc_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/htfc_frame.sv
// Reply framing: byte position, running CRC-8 and captured words.
// Depends on htfc_pkg.
module htfc_frame import htfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             start_i,
  output frame_t           frame_o
);

  logic [PosW-1:0]  pos_q, pos_d, pos;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [WordW-1:0] temp_q, temp_d;
  logic [ByteW-1:0] hhi_q, hhi_d;
  logic [ByteW-1:0] hlo_q, hlo_d;
  logic             tbad_q, tbad_d;
  logic             last;

  assign pos = start_i ? POS_T_MSB : pos_q;

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    temp_d = temp_q;
    hhi_d  = hhi_q;
    hlo_d  = hlo_q;
    tbad_d = tbad_q;
    last   = 1'b0;
    case (pos)
      POS_T_MSB: begin
        crc_d  = crc_feed(CrcInit, byte_i);
        temp_d = {byte_i, ByteW'(0)};
        pos_d  = POS_T_LSB;
      end
      POS_T_LSB: begin
        crc_d  = crc_feed(crc_q, byte_i);
        temp_d = {temp_q[WordW-1:ByteW], byte_i};
        pos_d  = POS_T_CRC;
      end
      POS_T_CRC: begin
        tbad_d = (crc_q != byte_i);
        crc_d  = CrcInit;
        pos_d  = POS_H_MSB;
      end
      POS_H_MSB: begin
        crc_d = crc_feed(CrcInit, byte_i);
        hhi_d = byte_i;
        pos_d = POS_H_LSB;
      end
      POS_H_LSB: begin
        crc_d = crc_feed(crc_q, byte_i);
        hlo_d = byte_i;
        pos_d = pos_q + PosW'(1);
      end
      default: begin
        last   = 1'b1;
        crc_d  = CrcInit;
        tbad_d = 1'b0;
        pos_d  = POS_T_MSB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_T_MSB;
      crc_q  <= CrcInit;
      temp_q <= '0;
      hhi_q  <= '0;
      hlo_q  <= '0;
      tbad_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      temp_q <= temp_d;
      hhi_q  <= hhi_d;
      hlo_q  <= hlo_d;
      tbad_q <= tbad_d;
    end
  end

  assign frame_o.last       = last;
  assign frame_o.temp_bad   = tbad_q;
  assign frame_o.humi_bad   = (crc_q != byte_i);
  assign frame_o.temp_ticks = temp_q;
  assign frame_o.humi_ticks = {hhi_q, hlo_q};

endmodule

FILE: rtl/htfc_conv.sv
// Status select and fixed-point conversion of both words to hundredths.
// Divide by 65535 is done as high half plus a one-step correction.
// Depends on htfc_pkg.
module htfc_conv import htfc_pkg::*; (
  input  frame_t                 frame_i,
  output logic signed [ValW-1:0] temp_o,
  output logic signed [ValW-1:0] humi_o,
  output logic [StatW-1:0]       status_o
);

  localparam int unsigned TQW = TProdW - WordW;
  localparam int unsigned HQW = HProdW - WordW;

  logic [TProdW-1:0] t_prod;
  logic [HProdW-1:0] h_prod;
  logic [WordW:0]    t_sum, h_sum;
  logic [TQW-1:0]    t_quo;
  logic [HQW-1:0]    h_quo;
  logic [ValW:0]     t_val, h_val;
  logic              ok;

  assign t_prod = TempScale * TProdW'(frame_i.temp_ticks);
  assign h_prod = HumiScale * HProdW'(frame_i.humi_ticks);

  // x / 65535 = hi + ((hi + lo) >= 65535), hi + lo stays below 2*65535
  assign t_sum = (WordW+1)'(t_prod[TProdW-1:WordW]) + (WordW+1)'(t_prod[WordW-1:0]);
  assign h_sum = (WordW+1)'(h_prod[HProdW-1:WordW]) + (WordW+1)'(h_prod[WordW-1:0]);
  assign t_quo = t_prod[TProdW-1:WordW] + TQW'(t_sum >= WordMax);
  assign h_quo = h_prod[HProdW-1:WordW] + HQW'(h_sum >= WordMax);

  assign t_val = (ValW+1)'(t_quo) - TempOffset;
  assign h_val = (ValW+1)'(h_quo) - HumiOffset;

  assign ok = !frame_i.temp_bad && !frame_i.humi_bad;

  always_comb begin
    if (frame_i.temp_bad) begin
      status_o = STAT_TEMP_BAD;
    end else if (frame_i.humi_bad) begin
      status_o = STAT_HUMI_BAD;
    end else begin
      status_o = STAT_OK;
    end
  end

  assign temp_o = ok ? $signed(t_val[ValW-1:0]) : '0;
  assign humi_o = ok ? $signed(h_val[ValW-1:0]) : '0;

endmodule

FILE: rtl/humidity_temp_frame_check_convert_top.sv
// Top level: input register, reply framing, conversion, result register.
// Depends on htfc_pkg, htfc_frame, htfc_conv.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o   | data_byte_i, frame_start_i
//   out     | output    | out_valid_o / out_stall_i | temperature_centi_o,
//           |           |                          | humidity_centi_o, status_o
//
// One byte per cycle unless a stalled result holds the sixth byte; the
// sixth byte enters the input register, then the result register loads.
// Reset clears the byte position, CRC and the captured words.
// A stalled result holds only the sixth byte of the next reply in the
// input register; other bytes keep flowing while the result waits.
module humidity_temp_frame_check_convert_top import htfc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ByteW-1:0]       data_byte_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] temperature_centi_o,
  output logic signed [ValW-1:0] humidity_centi_o,
  output logic [StatW-1:0]       status_o
);

  logic                   in_vld_q;
  logic [ByteW-1:0]       byte_q;
  logic                   start_q;
  logic                   adv;
  logic                   out_load;
  logic                   out_vld_q;
  logic signed [ValW-1:0] temp_q, humi_q;
  logic [StatW-1:0]       stat_q;
  frame_t                 frame;
  logic signed [ValW-1:0] temp_c, humi_c;
  logic [StatW-1:0]       stat_c;

  assign adv        = in_vld_q && (!frame.last || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign out_load   = adv && frame.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  htfc_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .byte_i  (byte_q),
    .start_i (start_q),
    .frame_o (frame)
  );

  htfc_conv u_conv (
    .frame_i  (frame),
    .temp_o   (temp_c),
    .humi_o   (humi_c),
    .status_o (stat_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      temp_q <= temp_c;
      humi_q <= humi_c;
      stat_q <= stat_c;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = humi_q;
  assign status_o            = stat_q;

endmodule
